// ----- rtl/core/e2q_pkg.sv -----
package e2q_pkg;

  localparam int unsigned AngW   = 16;
  localparam int unsigned QuatW  = 17;
  localparam int unsigned CordW  = 34;
  localparam int unsigned TrigW  = 22;
  localparam int unsigned PairW  = 23;
  localparam int unsigned AtanEntries = 24;

  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [CordW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [QuatW-1:0] OutMax    = 17'sd32768;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    cord_t z;
    logic  flip;
  } rot_t;

  function automatic cord_t atan_lut(input logic [4:0] idx);
    cord_t r;
    case (idx)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/e2q_if.sv -----
interface e2q_ang_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [e2q_pkg::AngW-1:0]      yaw_angle;
  logic signed [e2q_pkg::AngW-1:0]      pitch_angle;
  logic signed [e2q_pkg::AngW-1:0]      roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface e2q_quat_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [e2q_pkg::QuatW-1:0]     quat_w;
  logic signed [e2q_pkg::QuatW-1:0]     quat_x;
  logic signed [e2q_pkg::QuatW-1:0]     quat_y;
  logic signed [e2q_pkg::QuatW-1:0]     quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- rtl/core/e2q_cell.sv -----
// One CORDIC micro-rotation, registered. Holds when en_i is low.
module e2q_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  e2q_pkg::rot_t  rot_i,
  output e2q_pkg::rot_t  rot_o
);
  e2q_pkg::rot_t rot_d, rot_q;
  e2q_pkg::cord_t dx, dy, at;

  always_comb begin
    dx = rot_i.x >>> Stage;
    dy = rot_i.y >>> Stage;
    at = e2q_pkg::atan_lut(5'(Stage));
    rot_d = rot_i;
    if (!rot_i.z[e2q_pkg::CordW-1]) begin
      rot_d.x = rot_i.x - dy;
      rot_d.y = rot_i.y + dx;
      rot_d.z = rot_i.z - at;
    end else begin
      rot_d.x = rot_i.x + dy;
      rot_d.y = rot_i.y - dx;
      rot_d.z = rot_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;
endmodule

// ----- rtl/core/e2q_chain.sv -----
// Folds a half angle into +-pi/2 and runs it down the cell row.
module e2q_chain #(
  parameter int unsigned Stages = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [e2q_pkg::AngW-1:0]    ang_i,
  output e2q_pkg::trig_t                     cos_o,
  output e2q_pkg::trig_t                     sin_o
);
  e2q_pkg::rot_t chain [Stages+1];
  e2q_pkg::cord_t z0;
  e2q_pkg::cord_t xr, yr;

  always_comb begin
    z0 = {{(e2q_pkg::CordW-e2q_pkg::AngW-16){ang_i[e2q_pkg::AngW-1]}}, ang_i, 16'h0000};
    chain[0].x = e2q_pkg::GainQ30;
    chain[0].y = '0;
    chain[0].flip = 1'b0;
    chain[0].z = z0;
    if (z0 > e2q_pkg::HalfPiQ30) begin
      chain[0].z = z0 - e2q_pkg::PiQ30;
      chain[0].flip = 1'b1;
    end else if (z0 < -e2q_pkg::HalfPiQ30) begin
      chain[0].z = z0 + e2q_pkg::PiQ30;
      chain[0].flip = 1'b1;
    end
  end

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    e2q_cell #(.Stage(g)) u_cell (
      .clk_i, .en_i, .rot_i(chain[g]), .rot_o(chain[g+1])
    );
  end

  // sign fix then rounding (+512, floor); negation after rounding differs,
  // so negate first
  always_comb begin
    xr = chain[Stages].flip ? -chain[Stages].x : chain[Stages].x;
    yr = chain[Stages].flip ? -chain[Stages].y : chain[Stages].y;
    xr = (xr + 34'sd512) >>> 10;
    yr = (yr + 34'sd512) >>> 10;
    cos_o = xr[e2q_pkg::TrigW-1:0];
    sin_o = yr[e2q_pkg::TrigW-1:0];
  end
endmodule

// ----- rtl/core/e2q_mix.sv -----
// Pair products, then triple sums, rounded and saturated. Two register stages.
module e2q_mix (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  e2q_pkg::trig_t                   cy_i, sy_i, cp_i, sp_i, cr_i, sr_i,
  output logic signed [e2q_pkg::QuatW-1:0] w_o, x_o, y_o, z_o
);
  typedef logic signed [e2q_pkg::PairW-1:0] pair_t;
  typedef logic signed [47:0] wide_t;
  pair_t pcc_q, psc_q, pcs_q, pss_q;
  e2q_pkg::trig_t cy_q, sy_q;
  wide_t tw_d, tx_d, ty_d, tz_d;
  logic signed [e2q_pkg::QuatW-1:0] w_d, x_d, y_d, z_d;

  function automatic pair_t pr(input e2q_pkg::trig_t a, input e2q_pkg::trig_t b);
    logic signed [43:0] p;
    p = (44'(a) * 44'(b) + 44'sd524288) >>> 20;
    return p[e2q_pkg::PairW-1:0];
  endfunction

  function automatic logic signed [e2q_pkg::QuatW-1:0] fin(input wide_t v);
    wide_t r;
    r = (v + 48'sd16777216) >>> 25;
    if (r > 48'sd32768) r = 48'sd32768;
    if (r < -48'sd32768) r = -48'sd32768;
    return r[e2q_pkg::QuatW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pcc_q <= pr(cr_i, cp_i);
      psc_q <= pr(sr_i, cp_i);
      pcs_q <= pr(cr_i, sp_i);
      pss_q <= pr(sr_i, sp_i);
      cy_q  <= cy_i;
      sy_q  <= sy_i;
    end
  end

  always_comb begin
    tw_d = 48'(pcc_q) * 48'(cy_q) + 48'(pss_q) * 48'(sy_q);
    tx_d = 48'(psc_q) * 48'(cy_q) - 48'(pcs_q) * 48'(sy_q);
    ty_d = 48'(pcs_q) * 48'(cy_q) + 48'(psc_q) * 48'(sy_q);
    tz_d = 48'(pcc_q) * 48'(sy_q) - 48'(pss_q) * 48'(cy_q);
    w_d = fin(tw_d);
    x_d = fin(tx_d);
    y_d = fin(ty_d);
    z_d = fin(tz_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_o <= w_d;
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end
endmodule

// ----- rtl/core/euler_to_quaternion_core.sv -----
// Euler angles (yaw, pitch, roll; Q3.13 rad) to unit quaternion (Q2.15).
// ang: sink channel, one attitude word per handshake.
// quat: source channel, w/x/y/z saturated to +-1.0.
// Each angle is halved and sent down its own row of CORDIC_STAGES cells;
// each cell does one micro-rotation and hands x/y/z on every cycle that the pipe advances.
// After the rows: one stage of pair products, one of triple sums.
// Throughput: one word per cycle unless stalled. The whole pipe advances together; it
// freezes only when the output stage holds a word the receiver has not
// taken, so a stalled receiver backs up to ang.ready at once.
// Reset clears the valid pipe only; data registers are not reset.
module euler_to_quaternion_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  e2q_ang_if.sink      ang,
  e2q_quat_if.source   quat
);
  localparam int unsigned Depth = CORDIC_STAGES + 2;

  logic [Depth-1:0] vld_q, vld_d;
  logic en;
  e2q_pkg::trig_t cy, sy, cp, sp, cr, sr;

  // advance when the output slot is empty or being drained
  assign en        = !vld_q[Depth-1] || quat.ready;
  assign ang.ready = en;
  assign quat.valid = vld_q[Depth-1];

  assign vld_d = {vld_q[Depth-2:0], ang.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  e2q_chain #(.Stages(CORDIC_STAGES)) u_yaw (
    .clk_i, .en_i(en), .ang_i(ang.yaw_angle), .cos_o(cy), .sin_o(sy));
  e2q_chain #(.Stages(CORDIC_STAGES)) u_pitch (
    .clk_i, .en_i(en), .ang_i(ang.pitch_angle), .cos_o(cp), .sin_o(sp));
  e2q_chain #(.Stages(CORDIC_STAGES)) u_roll (
    .clk_i, .en_i(en), .ang_i(ang.roll_angle), .cos_o(cr), .sin_o(sr));

  e2q_mix u_mix (
    .clk_i, .en_i(en),
    .cy_i(cy), .sy_i(sy), .cp_i(cp), .sp_i(sp), .cr_i(cr), .sr_i(sr),
    .w_o(quat.quat_w), .x_o(quat.quat_x), .y_o(quat.quat_y), .z_o(quat.quat_z)
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quat.valid && !quat.ready |=> quat.valid && $stable(quat.quat_w))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !quat.valid |-> ang.ready)
    else $error("input blocked with empty output");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quat.valid |-> (quat.quat_w <= 17'sd32768 && quat.quat_w >= -17'sd32768))
    else $error("w out of range");
endmodule
